FILE: rtl/fpg_pkg.sv
// Package with the types, register codes and reset values of the frame pacing governor.
`default_nettype none
package fpg_pkg;
    localparam int MAX_WINDOW_DEF     = 512;
    localparam int WINDOW_SECONDS_DEF = 2;

    localparam logic [7:0] IDEAL_RST   = 8'd60;
    localparam logic [3:0] SKIPMAX_RST = 4'd3;
    localparam logic [9:0] MS_PER_S    = 10'd1000;

    localparam logic [1:0] REG_IDEAL   = 2'd0;
    localparam logic [1:0] REG_ENABLE  = 2'd1;
    localparam logic [1:0] REG_SKIPMAX = 2'd2;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    typedef struct packed {
        logic [15:0] show_ms;
        logic [15:0] frame_ms;
        logic        adjust_due;
        logic        no_sleep_done;
    } t_in;

    typedef struct packed {
        logic        shown;
        logic [9:0]  avg_fps;
        logic [9:0]  potential_fps;
        logic [3:0]  skip_count;
        logic        sleep_allowed;
        logic [9:0]  period_ms;
        logic [1:0]  nosleep_timer_action;
        logic [31:0] frames_total;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_DIVP, S_AVGP, S_DIVA, S_AVGA, S_ADJ,
        S_RRATE, S_RFAST, S_RPER, S_STEP, S_OUT
    } t_state;
endpackage
`default_nettype wire

FILE: rtl/frame_pacing_frameskip_governor.sv
// Top level of the frame pacing and adaptive frame-skip governor.
// One frame event per transaction gives one result transaction. A skipped frame does no division;
// a shown frame runs up to four divisions on one shared bit-serial divider that resolves one
// quotient bit per cycle; a skip change adds up to three more divisions. Writing ideal_fps
// restarts pacing at skip zero. The sample windows live in two synchronous RAMs; a fill pointer
// replaces any clearing pass, so they are not refilled after reset or a skip change.
`default_nettype none
module frame_pacing_frameskip_governor #(
    parameter int MAX_WINDOW     = fpg_pkg::MAX_WINDOW_DEF,
    parameter int WINDOW_SECONDS = fpg_pkg::WINDOW_SECONDS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire fpg_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output fpg_pkg::t_out      o_out,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam int WW = $clog2(MAX_WINDOW + 1);
    localparam int SW = 10 + WW;
    localparam int DW = SW;
    localparam int CW = $clog2(DW + 1);
    localparam int RST_WIN = (int'(fpg_pkg::IDEAL_RST) * WINDOW_SECONDS > MAX_WINDOW) ?
                             MAX_WINDOW : int'(fpg_pkg::IDEAL_RST) * WINDOW_SECONDS;
    localparam int RST_SUM = int'(fpg_pkg::IDEAL_RST) * RST_WIN;

    fpg_pkg::t_state r_state, n_state;

    logic [7:0]  r_ideal, n_ideal;
    logic        r_en, n_en;
    logic [3:0]  r_skip_max, n_skip_max;

    fpg_pkg::t_in r_in, n_in;
    logic         r_shown, n_shown;
    logic [1:0]   r_action, n_action;
    logic         r_from_cfg, n_from_cfg;

    logic [SW-1:0] r_psum, n_psum, r_asum, n_asum;
    logic [AW-1:0] r_head, n_head;
    logic          r_full, n_full;
    logic [9:0]    r_afps, n_afps, r_pfps, n_pfps;
    logic [3:0]    r_skip, n_skip, r_phase, n_phase;
    logic [9:0]    r_rate, n_rate, r_slow, n_slow, r_fast, n_fast, r_period, n_period;
    logic          r_sleep, n_sleep;
    logic [31:0]   r_total, n_total;

    logic          r_ov, n_ov;
    fpg_pkg::t_out r_out, n_out;

    logic [9:0] mem_p [MAX_WINDOW];
    logic [9:0] mem_a [MAX_WINDOW];
    logic [9:0] r_prd, r_ard;
    logic       we_p, we_a, rd_en;
    logic [9:0] wr_val;

    logic [DW-1:0] r_dq;
    logic [15:0]   r_dr, r_dd;
    logic [CW-1:0] r_dc;
    logic          r_dv_busy, r_dv_fin;
    logic          dv_need, dv_start;
    logic [DW-1:0] dv_num;
    logic [15:0]   dv_den;
    logic [16:0]   dv_sh;
    logic          dv_ge;

    logic          cfg_wr, cfg_ideal;
    logic          accept, out_go;
    logic [7:0]    eff_id;
    logic [9:0]    wprod;
    logic [WW-1:0] w_len;
    logic [15:0]   frame_den;
    logic [9:0]    old_p, old_a, rate_q;
    logic          adj, up, dn, change;
    logic [3:0]    ns;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign cfg_ideal = cfg_wr && (paddr[3:2] == fpg_pkg::REG_IDEAL);
    assign o_in_stall = (r_state != fpg_pkg::S_IDLE) || cfg_ideal;
    assign accept    = i_in_valid && !o_in_stall;
    assign out_go    = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out     = r_out;

    always_comb begin
        case (paddr[3:2])
            fpg_pkg::REG_IDEAL:   prdata = {24'd0, r_ideal};
            fpg_pkg::REG_ENABLE:  prdata = {31'd0, r_en};
            fpg_pkg::REG_SKIPMAX: prdata = {28'd0, r_skip_max};
            default:              prdata = 32'd0;
        endcase
    end

    assign eff_id    = (r_ideal == 8'd0) ? 8'd1 : r_ideal;
    assign wprod     = 10'(32'(eff_id) * WINDOW_SECONDS);
    assign w_len     = (32'(wprod) > MAX_WINDOW) ? WW'(MAX_WINDOW) : WW'(wprod);
    assign frame_den = (r_in.frame_ms == 16'd0) ? 16'd1 : r_in.frame_ms;
    assign old_p     = r_full ? r_prd : r_rate;
    assign old_a     = r_full ? r_ard : r_rate;
    assign rate_q    = (r_dq == DW'(0)) ? 10'd1 : r_dq[9:0];

    assign adj    = r_en && r_in.adjust_due;
    assign up     = (r_pfps <= r_slow) && (r_skip < r_skip_max);
    assign dn     = (r_pfps >= r_fast) && (r_skip != 4'd0);
    assign change = adj && (up || dn);
    assign ns     = up ? r_skip + 4'd1 : r_skip - 4'd1;

    always_comb begin
        dv_need = 1'b0;
        dv_num  = DW'(fpg_pkg::MS_PER_S);
        dv_den  = 16'd1;
        case (r_state)
            fpg_pkg::S_DIVP: begin
                dv_need = (r_in.show_ms != 16'd0);
                dv_den  = r_in.show_ms;
            end
            fpg_pkg::S_AVGP: begin
                dv_need = 1'b1;
                dv_num  = r_psum;
                dv_den  = 16'(w_len);
            end
            fpg_pkg::S_DIVA: begin
                dv_need = 1'b1;
                dv_den  = frame_den;
            end
            fpg_pkg::S_AVGA: begin
                dv_need = 1'b1;
                dv_num  = r_asum;
                dv_den  = 16'(w_len);
            end
            fpg_pkg::S_RRATE: begin
                dv_need = 1'b1;
                dv_num  = DW'(eff_id);
                dv_den  = 16'(r_skip) + 16'd1;
            end
            fpg_pkg::S_RFAST: begin
                dv_need = (r_skip != 4'd0);
                dv_num  = DW'(eff_id);
                dv_den  = 16'(r_skip);
            end
            fpg_pkg::S_RPER: begin
                dv_need = 1'b1;
                dv_den  = 16'(r_rate);
            end
            default: begin
                dv_need = 1'b0;
            end
        endcase
    end

    assign dv_start = dv_need && !r_dv_busy && !r_dv_fin;
    assign dv_sh    = {r_dr, r_dq[DW-1]};
    assign dv_ge    = dv_sh >= {1'b0, r_dd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_busy <= 1'b0;
            r_dv_fin  <= 1'b0;
        end else if (dv_start) begin
            r_dv_busy <= 1'b1;
            r_dv_fin  <= 1'b0;
        end else if (r_dv_busy) begin
            if (r_dc == CW'(1)) begin
                r_dv_busy <= 1'b0;
                r_dv_fin  <= 1'b1;
            end
        end else begin
            r_dv_fin <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_start) begin
            r_dq <= dv_num;
            r_dr <= 16'd0;
            r_dd <= dv_den;
            r_dc <= CW'(DW);
        end else if (r_dv_busy) begin
            r_dr <= dv_ge ? 16'(dv_sh - {1'b0, r_dd}) : dv_sh[15:0];
            r_dq <= {r_dq[DW-2:0], dv_ge};
            r_dc <= r_dc - CW'(1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fpg_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (r_phase == r_skip) ? fpg_pkg::S_DIVP : fpg_pkg::S_STEP;
                end
            end
            fpg_pkg::S_DIVP: begin
                if (r_in.show_ms == 16'd0) begin
                    n_state = fpg_pkg::S_DIVA;
                end else if (r_dv_fin) begin
                    n_state = fpg_pkg::S_AVGP;
                end
            end
            fpg_pkg::S_AVGP:  if (r_dv_fin) n_state = fpg_pkg::S_DIVA;
            fpg_pkg::S_DIVA:  if (r_dv_fin) n_state = fpg_pkg::S_AVGA;
            fpg_pkg::S_AVGA:  if (r_dv_fin) n_state = fpg_pkg::S_ADJ;
            fpg_pkg::S_ADJ:   n_state = change ? fpg_pkg::S_RRATE : fpg_pkg::S_STEP;
            fpg_pkg::S_RRATE: if (r_dv_fin) n_state = fpg_pkg::S_RFAST;
            fpg_pkg::S_RFAST: begin
                if (r_skip == 4'd0 || r_dv_fin) begin
                    n_state = fpg_pkg::S_RPER;
                end
            end
            fpg_pkg::S_RPER: begin
                if (r_dv_fin) begin
                    n_state = r_from_cfg ? fpg_pkg::S_IDLE : fpg_pkg::S_STEP;
                end
            end
            fpg_pkg::S_STEP:  n_state = fpg_pkg::S_OUT;
            fpg_pkg::S_OUT:   if (out_go) n_state = fpg_pkg::S_IDLE;
            default:          n_state = fpg_pkg::S_IDLE;
        endcase
        if (cfg_ideal) begin
            n_state = fpg_pkg::S_RRATE;
        end
    end

    always_comb begin
        n_ideal = r_ideal;  n_en = r_en;  n_skip_max = r_skip_max;
        n_in = r_in;  n_shown = r_shown;  n_action = r_action;  n_from_cfg = r_from_cfg;
        n_psum = r_psum;  n_asum = r_asum;  n_head = r_head;  n_full = r_full;
        n_afps = r_afps;  n_pfps = r_pfps;  n_skip = r_skip;  n_phase = r_phase;
        n_rate = r_rate;  n_slow = r_slow;  n_fast = r_fast;  n_period = r_period;
        n_sleep = r_sleep;  n_total = r_total;
        n_ov = r_ov && i_out_stall;  n_out = r_out;
        we_p = 1'b0;  we_a = 1'b0;  rd_en = 1'b0;
        wr_val = r_dq[9:0];

        if (cfg_wr) begin
            case (paddr[3:2])
                fpg_pkg::REG_IDEAL: begin
                    n_ideal    = pwdata[7:0];
                    n_skip     = 4'd0;
                    n_from_cfg = 1'b1;
                end
                fpg_pkg::REG_ENABLE:  n_en = pwdata[0];
                fpg_pkg::REG_SKIPMAX: n_skip_max = pwdata[3:0];
                default: ;
            endcase
        end

        case (r_state)
            fpg_pkg::S_IDLE: begin
                if (accept) begin
                    n_in       = i_in;
                    n_shown    = (r_phase == r_skip);
                    n_total    = r_total + 32'd1;
                    n_action   = fpg_pkg::ACT_NONE;
                    n_from_cfg = 1'b0;
                    rd_en      = 1'b1;
                end
            end
            fpg_pkg::S_DIVP: begin
                if (r_in.show_ms == 16'd0) begin
                    // The entry keeps the refill rate, so store it while the window fills.
                    we_p   = !r_full;
                    wr_val = r_rate;
                end else if (r_dv_fin) begin
                    we_p   = 1'b1;
                    n_psum = r_psum - SW'(old_p) + SW'(r_dq[9:0]);
                end
            end
            fpg_pkg::S_AVGP: if (r_dv_fin) n_pfps = r_dq[9:0];
            fpg_pkg::S_DIVA: begin
                if (r_dv_fin) begin
                    we_a   = 1'b1;
                    n_asum = r_asum - SW'(old_a) + SW'(r_dq[9:0]);
                end
            end
            fpg_pkg::S_AVGA: begin
                if (r_dv_fin) begin
                    n_afps = r_dq[9:0];
                    if (WW'(r_head) + WW'(1) == w_len) begin
                        n_head = '0;
                        n_full = 1'b1;
                    end else begin
                        n_head = r_head + AW'(1);
                    end
                end
            end
            fpg_pkg::S_ADJ: begin
                if (change) begin
                    n_action = (ns == 4'd0) ? fpg_pkg::ACT_START : fpg_pkg::ACT_STOP;
                    n_sleep  = 1'b0;
                    n_skip   = ns;
                end else if (adj && !r_sleep && r_in.no_sleep_done) begin
                    n_sleep = 1'b1;
                end
            end
            fpg_pkg::S_RRATE: begin
                if (r_dv_fin) begin
                    n_rate  = rate_q;
                    n_afps  = rate_q;
                    n_pfps  = rate_q;
                    n_head  = '0;
                    n_full  = 1'b0;
                    n_phase = 4'd0;
                    n_slow  = rate_q - 10'd2;
                end
            end
            fpg_pkg::S_RFAST: begin
                n_psum = SW'(r_rate) * SW'(w_len);
                n_asum = SW'(r_rate) * SW'(w_len);
                if (r_dv_fin) n_fast = r_dq[9:0];
            end
            fpg_pkg::S_RPER: if (r_dv_fin) n_period = r_dq[9:0];
            fpg_pkg::S_STEP: begin
                if (r_en) begin
                    n_phase = (r_phase == r_skip) ? 4'd0 : r_phase + 4'd1;
                end
            end
            fpg_pkg::S_OUT: begin
                if (out_go) begin
                    n_ov                       = 1'b1;
                    n_out.shown                = r_shown;
                    n_out.avg_fps              = r_afps;
                    n_out.potential_fps        = r_pfps;
                    n_out.skip_count           = r_skip;
                    n_out.sleep_allowed        = r_sleep;
                    n_out.period_ms            = r_period;
                    n_out.nosleep_timer_action = r_action;
                    n_out.frames_total         = r_total;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_p) mem_p[r_head] <= wr_val;
        if (we_a) mem_a[r_head] <= wr_val;
        if (rd_en) begin
            r_prd <= mem_p[r_head];
            r_ard <= mem_a[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= fpg_pkg::S_IDLE;
            r_ideal    <= fpg_pkg::IDEAL_RST;
            r_en       <= 1'b0;
            r_skip_max <= fpg_pkg::SKIPMAX_RST;
            r_action   <= fpg_pkg::ACT_NONE;
            r_from_cfg <= 1'b0;
            r_psum     <= SW'(RST_SUM);
            r_asum     <= SW'(RST_SUM);
            r_head     <= '0;
            r_full     <= 1'b0;
            r_afps     <= 10'(fpg_pkg::IDEAL_RST);
            r_pfps     <= 10'(fpg_pkg::IDEAL_RST);
            r_skip     <= 4'd0;
            r_phase    <= 4'd0;
            r_rate     <= 10'(fpg_pkg::IDEAL_RST);
            r_slow     <= 10'(fpg_pkg::IDEAL_RST) - 10'd2;
            r_fast     <= 10'd0;
            r_period   <= fpg_pkg::MS_PER_S / 10'(fpg_pkg::IDEAL_RST);
            r_sleep    <= 1'b1;
            r_total    <= 32'd0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ideal    <= n_ideal;
            r_en       <= n_en;
            r_skip_max <= n_skip_max;
            r_action   <= n_action;
            r_from_cfg <= n_from_cfg;
            r_psum     <= n_psum;
            r_asum     <= n_asum;
            r_head     <= n_head;
            r_full     <= n_full;
            r_afps     <= n_afps;
            r_pfps     <= n_pfps;
            r_skip     <= n_skip;
            r_phase    <= n_phase;
            r_rate     <= n_rate;
            r_slow     <= n_slow;
            r_fast     <= n_fast;
            r_period   <= n_period;
            r_sleep    <= n_sleep;
            r_total    <= n_total;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in    <= n_in;
        r_shown <= n_shown;
        r_out   <= n_out;
    end
endmodule
`default_nettype wire
